// File: design/clp_pkg.sv
// clp_pkg: types, codes and helper functions shared by the content-length parser
// no dependencies; imported by every module of the parser
`default_nettype none

package clp_pkg;

    localparam int CH_W  = 8;
    localparam int LEN_W = 31;
    localparam int ST_W  = 2;

    // largest accum that may still take another digit, and its last legal digit
    localparam logic [LEN_W-1:0] BIG_PREFIX     = 31'd214748364;
    localparam logic [3:0]       BIG_LAST_DIGIT = 4'd7;

    localparam logic [CH_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CH_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CH_W-1:0] CH_COMMA = 8'h2C;
    localparam logic [CH_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CH_W-1:0] CH_NINE  = 8'h39;

    typedef enum logic [2:0] {
        DS_BREAK = 3'd0,
        DS_S1    = 3'd1,
        DS_S2    = 3'd2,
        DS_S3    = 3'd3,
        DS_S4    = 3'd4,
        DS_S5    = 3'd5
    } t_dfa_state;

    typedef enum logic [2:0] {
        CL_BAD   = 3'd0,
        CL_WS    = 3'd1,
        CL_COMMA = 3'd2,
        CL_DIGIT = 3'd3,
        CL_END   = 3'd4
    } t_char_class;

    typedef enum logic [ST_W-1:0] {
        STAT_OK  = 2'd0,
        STAT_BAD = 2'd1,
        STAT_BIG = 2'd2
    } t_status;

    typedef struct packed {
        logic [CH_W-1:0] ch;
        logic            end_mark;
    } t_in_item;

    typedef struct packed {
        logic [ST_W-1:0]  status;
        logic [LEN_W-1:0] length;
    } t_out_item;

    function automatic t_char_class classify(input logic [CH_W-1:0] c);
        t_char_class cls;
        if (c == CH_TAB || c == CH_SPACE) begin
            cls = CL_WS;
        end else if (c == CH_COMMA) begin
            cls = CL_COMMA;
        end else if (c >= CH_ZERO && c <= CH_NINE) begin
            cls = CL_DIGIT;
        end else begin
            cls = CL_BAD;
        end
        return cls;
    endfunction

    // grammar table; DS_BREAK means the character is not allowed here
    function automatic t_dfa_state dfa_next(input t_dfa_state st, input t_char_class cls);
        t_dfa_state nxt;
        nxt = DS_BREAK;
        unique case (st)
            DS_S1: begin
                unique case (cls)
                    CL_WS, CL_COMMA: nxt = DS_S1;
                    CL_DIGIT:        nxt = DS_S2;
                    default:         nxt = DS_BREAK;
                endcase
            end
            DS_S2: begin
                unique case (cls)
                    CL_WS:    nxt = DS_S3;
                    CL_COMMA: nxt = DS_S4;
                    CL_DIGIT: nxt = DS_S2;
                    CL_END:   nxt = DS_S5;
                    default:  nxt = DS_BREAK;
                endcase
            end
            DS_S3: begin
                unique case (cls)
                    CL_WS:    nxt = DS_S3;
                    CL_COMMA: nxt = DS_S4;
                    CL_END:   nxt = DS_S5;
                    default:  nxt = DS_BREAK;
                endcase
            end
            DS_S4: begin
                unique case (cls)
                    CL_WS, CL_COMMA: nxt = DS_S4;
                    CL_DIGIT:        nxt = DS_S2;
                    CL_END:          nxt = DS_S5;
                    default:         nxt = DS_BREAK;
                endcase
            end
            default: nxt = DS_BREAK;
        endcase
        return nxt;
    endfunction

endpackage

`default_nettype wire

// File: design/clp_in_reg.sv
// clp_in_reg: input register of the parser and the input-side stall
// depends on clp_pkg
`default_nettype none

module clp_in_reg
    import clp_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_stall,
    input  wire t_in_item i_in,
    input  wire logic     i_out_free,
    output logic          o_go,
    output t_in_item      o_item
);

    logic     r_valid;
    t_in_item r_item;
    logic     n_valid;
    logic     accept;

    // characters never wait; an end marker waits for a free result slot
    assign o_go       = r_valid && (!r_item.end_mark || i_out_free);
    assign o_in_stall = r_valid && !o_go;
    assign accept     = i_in_valid && !o_in_stall;
    assign o_item     = r_item;

    always_comb begin
        n_valid = r_valid;
        if (accept) begin
            n_valid = 1'b1;
        end else if (o_go) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= i_in;
        end
    end

endmodule

`default_nettype wire

// File: design/clp_step.sv
// clp_step: parser state and the per-character step (grammar, accumulate, compare)
// depends on clp_pkg
`default_nettype none

module clp_step
    import clp_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_go,
    input  wire t_in_item i_item,
    output logic          o_res_valid,
    output t_out_item     o_res
);

    t_dfa_state       r_dfa_state, n_dfa_state;
    logic [LEN_W-1:0] r_accum, n_accum;
    logic [LEN_W-1:0] r_first_length, n_first_length;
    logic             r_have_length, n_have_length;
    t_status          r_error_code, n_error_code;

    t_char_class      cls;
    t_dfa_state       nxt;
    logic [3:0]       digit;
    logic [LEN_W+3:0] times_ten;
    logic             too_big;
    logic             mismatch;
    t_status          res_status;

    assign cls       = i_item.end_mark ? CL_END : classify(i_item.ch);
    assign nxt       = dfa_next(r_dfa_state, cls);
    assign digit     = i_item.ch[3:0];
    assign times_ten = {3'b000, r_accum, 1'b0} + {1'b0, r_accum, 3'b000}
                     + {{(LEN_W){1'b0}}, digit};
    assign too_big   = (r_accum > BIG_PREFIX)
                     || (r_accum == BIG_PREFIX && digit > BIG_LAST_DIGIT);
    assign mismatch  = r_have_length && (r_first_length != r_accum);

    always_comb begin
        n_dfa_state    = r_dfa_state;
        n_accum        = r_accum;
        n_first_length = r_first_length;
        n_have_length  = r_have_length;
        n_error_code   = r_error_code;
        res_status     = r_error_code;
        o_res.length   = '0;

        if (!i_item.end_mark) begin
            // after the first error the characters are dropped
            if (r_error_code == STAT_OK) begin
                if (nxt == DS_BREAK) begin
                    n_error_code = STAT_BAD;
                end else begin
                    n_dfa_state = nxt;
                    if (cls == CL_DIGIT) begin
                        if (too_big) begin
                            n_error_code = STAT_BIG;
                        end else begin
                            n_accum = times_ten[LEN_W-1:0];
                        end
                    end else if (r_dfa_state == DS_S2) begin
                        if (mismatch) begin
                            n_error_code = STAT_BAD;
                        end else begin
                            n_first_length = r_accum;
                            n_have_length  = 1'b1;
                            n_accum        = '0;
                        end
                    end
                end
            end
        end else begin
            if (r_error_code == STAT_OK) begin
                if (nxt != DS_S5) begin
                    res_status = STAT_BAD;
                end else if (r_dfa_state == DS_S2) begin
                    // list ends on a number: it is the last one to check
                    if (mismatch) begin
                        res_status = STAT_BAD;
                    end else begin
                        o_res.length = r_accum;
                    end
                end else begin
                    o_res.length = r_first_length;
                end
            end
            // every end marker returns the parser to its start
            n_dfa_state    = DS_S1;
            n_accum        = '0;
            n_first_length = '0;
            n_have_length  = 1'b0;
            n_error_code   = STAT_OK;
        end
        o_res.status = res_status;
    end

    assign o_res_valid = i_go && i_item.end_mark;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dfa_state    <= DS_S1;
            r_accum        <= '0;
            r_first_length <= '0;
            r_have_length  <= 1'b0;
            r_error_code   <= STAT_OK;
        end else if (i_go) begin
            r_dfa_state    <= n_dfa_state;
            r_accum        <= n_accum;
            r_first_length <= n_first_length;
            r_have_length  <= n_have_length;
            r_error_code   <= n_error_code;
        end
    end

endmodule

`default_nettype wire

// File: design/clp_out_reg.sv
// clp_out_reg: result register of the parser
// depends on clp_pkg
`default_nettype none

module clp_out_reg
    import clp_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_res_valid,
    input  wire t_out_item i_res,
    output logic           o_free,
    output logic           o_out_valid,
    input  wire logic      i_out_stall,
    output t_out_item      o_out
);

    logic      r_valid;
    t_out_item r_res;
    logic      n_valid;

    // slot is free when empty or its result leaves at this edge
    assign o_free      = !r_valid || !i_out_stall;
    assign o_out_valid = r_valid;
    assign o_out       = r_res;

    always_comb begin
        n_valid = r_valid;
        if (i_res_valid) begin
            n_valid = 1'b1;
        end else if (r_valid && !i_out_stall) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_res_valid) begin
            r_res <= i_res;
        end
    end

endmodule

`default_nettype wire

// File: design/content_length_list_parser.sv
// content_length_list_parser: top level of the content-length list parser
// depends on clp_pkg, clp_in_reg, clp_step, clp_out_reg
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+--------------------------
//   in      | input     | i_in_valid / o_in_stall | i_in  (ch, end_mark)
//   out     | output    | o_out_valid / i_out_stall | o_out (status, length)
//
// one item per cycle while o_in_stall is low; an item is registered in the input
// register on its transfer and parsed from there, and an end marker's result is
// registered in the output register, from which it transfers on o_out
// the per-cycle limit is the state loop: grammar table, times-ten add, compare
// reset is synchronous, active low, and returns the parser to its start state
// a character never waits in the input register; an end marker waits there
// while a result is held in the output register and i_out_stall is high, and
// o_in_stall stays high behind it
`default_nettype none

module content_length_list_parser
    import clp_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_stall,
    input  wire t_in_item  i_in,
    output logic           o_out_valid,
    input  wire logic      i_out_stall,
    output t_out_item      o_out
);

    logic      go;
    logic      out_free;
    t_in_item  item;
    logic      res_valid;
    t_out_item res;

    clp_in_reg u_in_reg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in       (i_in),
        .i_out_free (out_free),
        .o_go       (go),
        .o_item     (item)
    );

    clp_step u_step (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_go        (go),
        .i_item      (item),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    clp_out_reg u_out_reg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_valid (res_valid),
        .i_res       (res),
        .o_free      (out_free),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

endmodule

`default_nettype wire

// File: design/clp_checker.sv
// clp_port_checks: port-level checks of the content-length parser, bound to the top level
// depends on clp_pkg and content_length_list_parser
`default_nettype none

module clp_port_checks
    import clp_pkg::*;
(
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      i_in_valid,
    input wire logic      o_in_stall,
    input wire t_in_item  i_in,
    input wire logic      o_out_valid,
    input wire logic      i_out_stall,
    input wire t_out_item o_out
);

    // a held result stays put until its transfer
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out))
        else $error("result changed while stalled");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out.status == STAT_OK || o_out.status == STAT_BAD
                         || o_out.status == STAT_BIG))
        else $error("undefined status code");

    a_err_len_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.status != STAT_OK |-> o_out.length == '0)
        else $error("length not zero on an error result");

    // input only waits behind a blocked result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled without a blocked result");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result pending right after reset");

endmodule

bind content_length_list_parser clp_port_checks u_clp_checker (.*);

`default_nettype wire
